/* sv/lnad_pkg.sv */
// Shared types, constants and register codes for the LIF neuron with axon delay.
package lnad_pkg;

    localparam int MAX_PACKETS = 8;
    localparam int CNT_W       = $clog2(MAX_PACKETS + 1);

    localparam int LEVEL_W    = 16;
    localparam int AGE_W      = 20;
    localparam int GAIN_W     = 24;
    localparam int GAIN_HALF  = GAIN_W / 2;
    localparam int ARR_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [AGE_W-1:0]          AGE_MAX   = '1;
    localparam logic [ARR_W-1:0]          ARR_MAX   = '1;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 16'sh7FFF;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = 16'sh8000;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_RESTING    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LVL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEAK_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AXON_DELAY = 3'd5;

    // register values after reset
    localparam logic signed [LEVEL_W-1:0] RESTING_RST    = -16'sd17920;
    localparam logic signed [LEVEL_W-1:0] THRESHOLD_RST  = -16'sd14080;
    localparam logic signed [LEVEL_W-1:0] RESET_LVL_RST  = -16'sd17920;
    localparam logic [GAIN_W-1:0]         LEAK_GAIN_RST  = 24'd1678;
    localparam logic [AGE_W-1:0]          REFRACTORY_RST = 20'd2000;
    localparam logic [AGE_W-1:0]          AXON_DELAY_RST = 20'd1000000;

    typedef enum logic {
        CMD_STIM = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] resting_level;
        logic signed [LEVEL_W-1:0] threshold_level;
        logic signed [LEVEL_W-1:0] reset_level;
        logic [GAIN_W-1:0]         leak_gain;
        logic [AGE_W-1:0]          refractory_period_us;
        logic [AGE_W-1:0]          axon_delay_us;
    } cfg_t;

    typedef struct packed {
        cmd_t                      command;
        logic signed [LEVEL_W-1:0] stimulus_mv;
        logic [AGE_W-1:0]          elapsed_us;
    } item_t;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] membrane_level;
        logic                      fired;
        logic [ARR_W-1:0]          arrivals;
        logic                      refractory_active;
        logic                      stimulus_accepted;
        logic                      packet_dropped;
        logic                      level_saturated;
    } result_t;

endpackage

/* sv/lnad_front.sv */
// Input side: accepts items, tags the command and holds them in a short queue.
module lnad_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                command,
    input  logic signed [lnad_pkg::LEVEL_W-1:0] stimulus_mv,
    input  logic [lnad_pkg::AGE_W-1:0]          elapsed_us,
    output logic                                q_valid,
    output lnad_pkg::item_t                     q_item,
    input  logic                                q_pop
);
    import lnad_pkg::*;

    item_t             queue_reg [QUEUE_DEPTH];
    item_t             item_in;
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;

    assign item_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push       = item_valid && !item_stall;
    assign q_valid    = (count_reg != '0);
    assign q_item     = queue_reg[rd_ptr_reg];

    // classify: the field the command does not use is carried as zero
    always_comb
    begin
        item_in.command     = command ? CMD_TICK : CMD_STIM;
        item_in.stimulus_mv = command ? '0 : stimulus_mv;
        item_in.elapsed_us  = command ? elapsed_us : '0;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, q_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= item_in;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != '0)
        else $error("pop from empty queue");

endmodule

/* sv/lnad_back.sv */
// Execution side: membrane update, leak multiply, packet store and result register.
module lnad_back (
    input  logic              clk,
    input  logic              rst_n,
    input  lnad_pkg::cfg_t    cfg,
    input  logic              q_valid,
    input  lnad_pkg::item_t   q_item,
    output logic              q_pop,
    output logic              result_valid,
    input  logic              result_stall,
    output lnad_pkg::result_t result
);
    import lnad_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL2,
        S_MUL3,
        S_LEAK,
        S_AGE
    } state_t;

    state_t                    state_reg, state_next;
    item_t                     op_reg, op_next;
    logic signed [LEVEL_W-1:0] membrane_reg, membrane_next;
    logic [AGE_W-1:0]          refr_reg, refr_next;
    logic [MAX_PACKETS-1:0]    valid_reg, valid_next;
    logic [AGE_W-1:0]          age_reg [MAX_PACKETS];
    logic [AGE_W-1:0]          age_next [MAX_PACKETS];
    logic                      neg_reg, neg_next;
    logic [35:0]               p1_reg, p1_next;
    logic [59:0]               acc_reg, acc_next;
    logic                      fired_reg, fired_next;
    logic                      dropped_reg, dropped_next;
    logic                      sat_reg, sat_next;
    result_t                   result_reg, result_next;
    logic                      result_valid_reg, result_valid_next;

    logic                      produce;
    logic                      accepted;
    logic [ARR_W-1:0]          arr_out;
    logic signed [LEVEL_W:0]   stim_sum;
    logic signed [LEVEL_W:0]   diff;
    logic [LEVEL_W:0]          mag_w;
    logic [GAIN_HALF-1:0]      gain_part;
    logic [47:0]               pp;
    logic [60:0]               rounded;
    logic [36:0]               q_mag;
    logic signed [37:0]        step;
    logic signed [38:0]        leak_sum;
    logic [MAX_PACKETS-1:0]    free_vec, lowest_free, arrive;
    logic [AGE_W:0]            age_sum [MAX_PACKETS];
    logic [AGE_W-1:0]          aged [MAX_PACKETS];
    logic [CNT_W-1:0]          arr_cnt;
    logic [CNT_W+ARR_W-1:0]    arr_wide;

    assign q_pop        = (state_reg == S_IDLE) && q_valid
                          && (!result_valid_reg || !result_stall);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // datapath pieces
    always_comb
    begin
        stim_sum  = {membrane_reg[LEVEL_W-1], membrane_reg}
                  + {op_reg.stimulus_mv[LEVEL_W-1], op_reg.stimulus_mv};
        diff      = {cfg.resting_level[LEVEL_W-1], cfg.resting_level}
                  - {membrane_reg[LEVEL_W-1], membrane_reg};
        mag_w     = diff[LEVEL_W] ? -diff : diff;
        gain_part = (state_reg == S_MUL2) ? cfg.leak_gain[GAIN_HALF-1:0]
                                          : cfg.leak_gain[GAIN_W-1:GAIN_HALF];
        pp        = {12'b0, p1_reg} * {36'b0, gain_part};
        rounded   = {1'b0, acc_reg} + 61'(1 << 23);
        q_mag     = rounded[60:24];
        step      = neg_reg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
        leak_sum  = $signed({{23{membrane_reg[LEVEL_W-1]}}, membrane_reg})
                  + $signed({step[37], step});

        free_vec    = ~valid_reg;
        lowest_free = free_vec & (~free_vec + MAX_PACKETS'(1));

        arr_cnt = '0;
        for (int i = 0; i < MAX_PACKETS; i++)
        begin
            age_sum[i] = {1'b0, age_reg[i]} + {1'b0, op_reg.elapsed_us};
            aged[i]    = age_sum[i][AGE_W] ? AGE_MAX : age_sum[i][AGE_W-1:0];
            arrive[i]  = valid_reg[i] && (aged[i] >= cfg.axon_delay_us);
            arr_cnt    = arr_cnt + CNT_W'(arrive[i]);
        end
        arr_wide = (CNT_W + ARR_W)'(arr_cnt);
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        membrane_next     = membrane_reg;
        refr_next         = refr_reg;
        valid_next        = valid_reg;
        neg_next          = neg_reg;
        p1_next           = p1_reg;
        acc_next          = acc_reg;
        fired_next        = fired_reg;
        dropped_next      = dropped_reg;
        sat_next          = sat_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        produce           = 1'b0;
        accepted          = 1'b0;
        arr_out           = '0;
        for (int i = 0; i < MAX_PACKETS; i++)
        begin
            age_next[i] = age_reg[i];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    op_next      = q_item;
                    fired_next   = 1'b0;
                    dropped_next = 1'b0;
                    sat_next     = 1'b0;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                priority if (op_reg.command == CMD_STIM)
                begin
                    if (refr_reg == '0)
                    begin
                        accepted = 1'b1;
                        if (stim_sum[LEVEL_W] != stim_sum[LEVEL_W-1])
                        begin
                            sat_next      = 1'b1;
                            membrane_next = stim_sum[LEVEL_W] ? LEVEL_MIN : LEVEL_MAX;
                        end
                        else
                        begin
                            membrane_next = stim_sum[LEVEL_W-1:0];
                        end
                    end
                    produce    = 1'b1;
                    state_next = S_IDLE;
                end
                else if (refr_reg != '0)
                begin
                    refr_next     = (refr_reg > op_reg.elapsed_us)
                                    ? refr_reg - op_reg.elapsed_us : '0;
                    membrane_next = cfg.reset_level;
                    produce       = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (membrane_reg >= cfg.threshold_level)
                begin
                    membrane_next = cfg.reset_level;
                    refr_next     = cfg.refractory_period_us;
                    fired_next    = 1'b1;
                    dropped_next  = (free_vec == '0);
                    valid_next    = valid_reg | lowest_free;
                    for (int i = 0; i < MAX_PACKETS; i++)
                    begin
                        if (lowest_free[i])
                        begin
                            age_next[i] = '0;
                        end
                    end
                    state_next = S_AGE;
                end
                else
                begin
                    neg_next   = diff[LEVEL_W];
                    p1_next    = {20'b0, mag_w[LEVEL_W-1:0]} * {16'b0, op_reg.elapsed_us};
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                acc_next   = {12'b0, pp};
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                acc_next   = acc_reg + {pp, 12'b0};
                state_next = S_LEAK;
            end
            S_LEAK:
            begin
                if (leak_sum > 39'sd32767)
                begin
                    sat_next      = 1'b1;
                    membrane_next = LEVEL_MAX;
                end
                else if (leak_sum < -39'sd32768)
                begin
                    sat_next      = 1'b1;
                    membrane_next = LEVEL_MIN;
                end
                else
                begin
                    membrane_next = leak_sum[LEVEL_W-1:0];
                end
                state_next = S_AGE;
            end
            S_AGE:
            begin
                for (int i = 0; i < MAX_PACKETS; i++)
                begin
                    if (valid_reg[i])
                    begin
                        age_next[i] = aged[i];
                    end
                end
                valid_next = valid_reg & ~arrive;
                arr_out    = (arr_wide > (CNT_W + ARR_W)'(ARR_MAX))
                             ? ARR_MAX : arr_wide[ARR_W-1:0];
                produce    = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (produce)
        begin
            result_next.membrane_level    = membrane_next;
            result_next.fired             = fired_next;
            result_next.arrivals          = arr_out;
            result_next.refractory_active = (refr_next != '0);
            result_next.stimulus_accepted = accepted;
            result_next.packet_dropped    = dropped_next;
            result_next.level_saturated   = sat_next;
            result_valid_next             = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            op_reg           <= '0;
            membrane_reg     <= RESTING_RST;
            refr_reg         <= '0;
            valid_reg        <= '0;
            neg_reg          <= 1'b0;
            p1_reg           <= '0;
            acc_reg          <= '0;
            fired_reg        <= 1'b0;
            dropped_reg      <= 1'b0;
            sat_reg          <= 1'b0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            op_reg           <= op_next;
            membrane_reg     <= membrane_next;
            refr_reg         <= refr_next;
            valid_reg        <= valid_next;
            neg_reg          <= neg_next;
            p1_reg           <= p1_next;
            acc_reg          <= acc_next;
            fired_reg        <= fired_next;
            dropped_reg      <= dropped_next;
            sat_reg          <= sat_next;
            result_reg       <= result_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // packet ages: meaningful only while the slot is valid
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_PACKETS; i++)
        begin
            age_reg[i] <= age_next[i];
        end
    end

    a_stim_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.stimulus_accepted
        |-> !result_reg.fired && result_reg.arrivals == '0 && !result_reg.packet_dropped)
        else $error("stimulus result carries tick flags");

    a_drop_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.packet_dropped |-> result_reg.fired)
        else $error("packet dropped without firing");

    a_sat_not_fire: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.level_saturated |-> !result_reg.fired)
        else $error("saturation reported on a firing tick");

endmodule

/* sv/lif_neuron_with_axon_delay_top.sv */
// Top level: configuration registers, input queue and executor of the LIF neuron.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+----------------------------------------------
//  item in   | item_valid / item_stall    | command, stimulus_mv, elapsed_us
//  result out| result_valid / result_stall| membrane_level, fired, arrivals,
//            |                            | refractory_active, stimulus_accepted,
//            |                            | packet_dropped, level_saturated
//  config    | cfg_we                     | cfg_index, cfg_data
//
// Executor states per item: S_EXEC for a stimulus or a refractory tick; S_EXEC, S_AGE
// for a firing tick; S_EXEC, S_MUL2, S_MUL3, S_LEAK, S_AGE for a leaking tick (a 16x20
// multiply, a 36x12 multiplier used twice over the halves of leak_gain, round, clamp).
// The executor works on one item at a time; a two-item queue keeps taking items meanwhile.
// Reset (rst_n low, async) loads register defaults, membrane = resting level, no refractory
// time and an empty packet store. A stalled result holds in its register; the next item
// is popped from the queue in the same cycle the waiting result is taken.
module lif_neuron_with_axon_delay_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [lnad_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lnad_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  logic                                  command,
    input  logic signed [lnad_pkg::LEVEL_W-1:0]   stimulus_mv,
    input  logic [lnad_pkg::AGE_W-1:0]            elapsed_us,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic signed [lnad_pkg::LEVEL_W-1:0]   membrane_level,
    output logic                                  fired,
    output logic [lnad_pkg::ARR_W-1:0]            arrivals,
    output logic                                  refractory_active,
    output logic                                  stimulus_accepted,
    output logic                                  packet_dropped,
    output logic                                  level_saturated
);
    import lnad_pkg::*;

    cfg_t    cfg_reg;
    logic    q_valid;
    item_t   q_item;
    logic    q_pop;
    result_t result;

    // configuration registers; indexes past the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.resting_level        <= RESTING_RST;
            cfg_reg.threshold_level      <= THRESHOLD_RST;
            cfg_reg.reset_level          <= RESET_LVL_RST;
            cfg_reg.leak_gain            <= LEAK_GAIN_RST;
            cfg_reg.refractory_period_us <= REFRACTORY_RST;
            cfg_reg.axon_delay_us        <= AXON_DELAY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RESTING:    cfg_reg.resting_level        <= cfg_data[LEVEL_W-1:0];
                REG_THRESHOLD:  cfg_reg.threshold_level      <= cfg_data[LEVEL_W-1:0];
                REG_RESET_LVL:  cfg_reg.reset_level          <= cfg_data[LEVEL_W-1:0];
                REG_LEAK_GAIN:  cfg_reg.leak_gain            <= cfg_data[GAIN_W-1:0];
                REG_REFRACTORY: cfg_reg.refractory_period_us <= cfg_data[AGE_W-1:0];
                REG_AXON_DELAY: cfg_reg.axon_delay_us        <= cfg_data[AGE_W-1:0];
                default:        cfg_reg                      <= cfg_reg;
            endcase
        end
    end

    lnad_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .command     (command),
        .stimulus_mv (stimulus_mv),
        .elapsed_us  (elapsed_us),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    lnad_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assign membrane_level    = result.membrane_level;
    assign fired             = result.fired;
    assign arrivals          = result.arrivals;
    assign refractory_active = result.refractory_active;
    assign stimulus_accepted = result.stimulus_accepted;
    assign packet_dropped    = result.packet_dropped;
    assign level_saturated   = result.level_saturated;

endmodule

/* tb/tb_lif_neuron_with_axon_delay_top.sv */
// Self-checking testbench for the LIF neuron with axon delay: directed cases, then random traffic.
`timescale 1ns / 1ps

module tb_lif_neuron_with_axon_delay_top;
    import lnad_pkg::*;

    // Run ends here regardless.
    localparam longint CYCLE_LIMIT   = 400000;
    // Cycles to let pass once the last output is in, before touching registers or ending.
    localparam int     SETTLE_CYCLES = 16;
    localparam int     PHASE_ITEMS   = 160;
    localparam int     AGE_TOP       = 1048575;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [CFG_DATA_W-1:0]        cfg_data;
    logic                         item_valid;
    logic                         item_stall;
    logic                         command;
    logic signed [LEVEL_W-1:0]    stimulus_mv;
    logic [AGE_W-1:0]             elapsed_us;
    logic                         result_valid;
    logic                         result_stall;
    logic signed [LEVEL_W-1:0]    membrane_level;
    logic                         fired;
    logic [ARR_W-1:0]             arrivals;
    logic                         refractory_active;
    logic                         stimulus_accepted;
    logic                         packet_dropped;
    logic                         level_saturated;

    // Neuron mirror: registers, membrane, refractory timer and the spike packet store.
    cfg_t                         nrn_cfg;
    logic signed [LEVEL_W-1:0]    nrn_level;
    logic [AGE_W-1:0]             nrn_refr_left;
    logic [AGE_W-1:0]             pkt_age [MAX_PACKETS];
    logic                         pkt_valid [MAX_PACKETS];

    // Outputs predicted for accepted items, oldest first.
    result_t                      neuron_outputs_q [$];

    int                           mismatches;
    int                           send_idle_pct;
    int                           stall_pct;
    longint                       cycle_count;

    lif_neuron_with_axon_delay_top u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .command           (command),
        .stimulus_mv       (stimulus_mv),
        .elapsed_us        (elapsed_us),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .membrane_level    (membrane_level),
        .fired             (fired),
        .arrivals          (arrivals),
        .refractory_active (refractory_active),
        .stimulus_accepted (stimulus_accepted),
        .packet_dropped    (packet_dropped),
        .level_saturated   (level_saturated)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Neuron mirror
    // ------------------------------------------------------------------

    function automatic void reset_neuron_mirror();
        nrn_cfg.resting_level        = RESTING_RST;
        nrn_cfg.threshold_level      = THRESHOLD_RST;
        nrn_cfg.reset_level          = RESET_LVL_RST;
        nrn_cfg.leak_gain            = LEAK_GAIN_RST;
        nrn_cfg.refractory_period_us = REFRACTORY_RST;
        nrn_cfg.axon_delay_us        = AXON_DELAY_RST;
        nrn_level                    = RESTING_RST;
        nrn_refr_left                = '0;
        for (int i = 0; i < MAX_PACKETS; i++)
        begin
            pkt_age[i]   = '0;
            pkt_valid[i] = 1'b0;
        end
    endfunction

    function automatic void mirror_reg_write(logic [CFG_IDX_W-1:0] idx,
                                             logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_RESTING:    nrn_cfg.resting_level        = data[LEVEL_W-1:0];
            REG_THRESHOLD:  nrn_cfg.threshold_level      = data[LEVEL_W-1:0];
            REG_RESET_LVL:  nrn_cfg.reset_level          = data[LEVEL_W-1:0];
            REG_LEAK_GAIN:  nrn_cfg.leak_gain            = data[GAIN_W-1:0];
            REG_REFRACTORY: nrn_cfg.refractory_period_us = data[AGE_W-1:0];
            REG_AXON_DELAY: nrn_cfg.axon_delay_us        = data[AGE_W-1:0];
            default: ;
        endcase
    endfunction

    // Clamp to the 16-bit level range, flagging when clamped.
    function automatic logic signed [LEVEL_W-1:0] clamp_level(input longint v,
                                                              output logic sat);
        sat = 1'b0;
        if (v > longint'(LEVEL_MAX))
        begin
            sat = 1'b1;
            return LEVEL_MAX;
        end
        if (v < longint'(LEVEL_MIN))
        begin
            sat = 1'b1;
            return LEVEL_MIN;
        end
        return v[LEVEL_W-1:0];
    endfunction

    // Applies one item to the mirror and returns the output it should produce.
    function automatic result_t advance_neuron(cmd_t cmd, logic signed [LEVEL_W-1:0] stim,
                                               logic [AGE_W-1:0] elapsed);
        result_t           r;
        longint            d;
        longint unsigned   mag;
        longint unsigned   q;
        longint            stepv;
        logic [AGE_W:0]    age_sum;
        logic              stored;
        r = '0;
        if (cmd == CMD_STIM)
        begin
            if (nrn_refr_left == '0)
            begin
                nrn_level = clamp_level(longint'(nrn_level) + longint'(stim),
                                        r.level_saturated);
                r.stimulus_accepted = 1'b1;
            end
        end
        else if (nrn_refr_left != '0)
        begin
            // refractory: count down only, potential pinned, packets frozen
            nrn_refr_left = (nrn_refr_left > elapsed) ? nrn_refr_left - elapsed : '0;
            nrn_level     = nrn_cfg.reset_level;
        end
        else
        begin
            if (nrn_level >= nrn_cfg.threshold_level)
            begin
                stored        = 1'b0;
                nrn_level     = nrn_cfg.reset_level;
                nrn_refr_left = nrn_cfg.refractory_period_us;
                r.fired       = 1'b1;
                for (int i = 0; i < MAX_PACKETS; i++)
                begin
                    if (!stored && !pkt_valid[i])
                    begin
                        pkt_valid[i] = 1'b1;
                        pkt_age[i]   = '0;
                        stored       = 1'b1;
                    end
                end
                r.packet_dropped = !stored;
            end
            else
            begin
                // forward Euler leak, rounded to nearest, ties away from zero
                d     = longint'(nrn_cfg.resting_level) - longint'(nrn_level);
                mag   = (d < 0) ? -d : d;
                q     = (mag * elapsed * nrn_cfg.leak_gain + (64'd1 << 23)) >> 24;
                stepv = (d < 0) ? -longint'(q) : longint'(q);
                nrn_level = clamp_level(longint'(nrn_level) + stepv, r.level_saturated);
            end
            for (int i = 0; i < MAX_PACKETS; i++)
            begin
                if (pkt_valid[i])
                begin
                    age_sum = {1'b0, pkt_age[i]} + {1'b0, elapsed};
                    pkt_age[i] = (age_sum > {1'b0, AGE_MAX}) ? AGE_MAX : age_sum[AGE_W-1:0];
                    if (pkt_age[i] >= nrn_cfg.axon_delay_us)
                    begin
                        pkt_valid[i] = 1'b0;
                        if (r.arrivals != ARR_MAX)
                            r.arrivals = r.arrivals + 1'b1;
                    end
                end
            end
        end
        r.membrane_level    = nrn_level;
        r.refractory_active = (nrn_refr_left != '0);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stall, checking, cycle limit
    // ------------------------------------------------------------------

    always @(negedge clk)
        result_stall <= ($urandom_range(0, 99) < stall_pct);

    function automatic void compare_outputs(result_t want, result_t got);
        if (got.membrane_level !== want.membrane_level)
        begin
            $error("membrane_level: expected %0d, got %0d",
                   want.membrane_level, got.membrane_level);
            mismatches++;
        end
        if (got.fired !== want.fired)
        begin
            $error("fired: expected %0d, got %0d", want.fired, got.fired);
            mismatches++;
        end
        if (got.arrivals !== want.arrivals)
        begin
            $error("arrivals: expected %0d, got %0d", want.arrivals, got.arrivals);
            mismatches++;
        end
        if (got.refractory_active !== want.refractory_active)
        begin
            $error("refractory_active: expected %0d, got %0d",
                   want.refractory_active, got.refractory_active);
            mismatches++;
        end
        if (got.stimulus_accepted !== want.stimulus_accepted)
        begin
            $error("stimulus_accepted: expected %0d, got %0d",
                   want.stimulus_accepted, got.stimulus_accepted);
            mismatches++;
        end
        if (got.packet_dropped !== want.packet_dropped)
        begin
            $error("packet_dropped: expected %0d, got %0d",
                   want.packet_dropped, got.packet_dropped);
            mismatches++;
        end
        if (got.level_saturated !== want.level_saturated)
        begin
            $error("level_saturated: expected %0d, got %0d",
                   want.level_saturated, got.level_saturated);
            mismatches++;
        end
    endfunction

    // An output item is taken at a rising edge with valid high and stall low.
    always @(posedge clk)
    begin : check_outputs
        result_t got;
        if (rst_n && result_valid && !result_stall)
        begin
            got.membrane_level    = membrane_level;
            got.fired             = fired;
            got.arrivals          = arrivals;
            got.refractory_active = refractory_active;
            got.stimulus_accepted = stimulus_accepted;
            got.packet_dropped    = packet_dropped;
            got.level_saturated   = level_saturated;
            if (neuron_outputs_q.size() == 0)
            begin
                $error("output item with nothing predicted: membrane_level %0d",
                       membrane_level);
                mismatches++;
            end
            else
                compare_outputs(neuron_outputs_q.pop_front(), got);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Entered and left at a falling edge. Valid stays high between back-to-back
    // items; it only drops during a random gap or a drain.
    task automatic send_item(input cmd_t cmd, input logic signed [LEVEL_W-1:0] stim,
                             input logic [AGE_W-1:0] elapsed);
        result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid  <= 1'b1;
        command     <= cmd;
        stimulus_mv <= stim;
        elapsed_us  <= elapsed;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predicted        = advance_neuron(cmd, stim, elapsed);
        neuron_outputs_q = {neuron_outputs_q, predicted};
        @(negedge clk);
    endtask

    // Random item: mostly moderate weights and short ticks so the neuron really
    // climbs, fires and ages packets; now and then full-range fields.
    task automatic send_random_item();
        cmd_t                      cmd;
        logic signed [LEVEL_W-1:0] stim;
        logic [AGE_W-1:0]          elapsed;
        int                        s;
        cmd = cmd_t'($urandom_range(0, 1));
        s   = $urandom_range(0, 8000);
        if ($urandom_range(0, 9) == 0)
            stim = LEVEL_W'($urandom);
        else
            stim = LEVEL_W'(s - 2000);
        case ($urandom_range(0, 9))
            0:       elapsed = '0;
            1:       elapsed = AGE_W'($urandom);
            default: elapsed = AGE_W'($urandom_range(0, 1500));
        endcase
        send_item(cmd, stim, elapsed);
    endtask

    // Sender holds off until every predicted output is in, then the block settles.
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (neuron_outputs_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // cfg_we is raised and then lowered on separate falling edges, so it never gets two updates in one step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        mirror_reg_write(idx, value[CFG_DATA_W-1:0]);
    endtask

    task automatic write_config(input int rest, input int thr, input int rlv,
                                input int gain, input int refr, input int delay);
        write_reg(REG_RESTING, rest);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_RESET_LVL, rlv);
        write_reg(REG_LEAK_GAIN, gain);
        write_reg(REG_REFRACTORY, refr);
        write_reg(REG_AXON_DELAY, delay);
    endtask

    // Threshold sits above rest within reach of a few stimuli; reset near rest.
    task automatic load_random_config();
        int rest;
        int thr;
        int rlv;
        int gain;
        int refr;
        int delay;
        rest = $urandom_range(0, 40000);
        rest = rest - 30000;
        thr  = rest + $urandom_range(0, 8000);
        rlv  = rest + $urandom_range(0, 6000);
        rlv  = rlv - 2000;
        case ($urandom_range(0, 5))
            0:       gain = 0;
            1:       gain = $urandom_range(0, 16777215);
            default: gain = $urandom_range(0, 20000);
        endcase
        case ($urandom_range(0, 5))
            0:       refr = 0;
            1:       refr = $urandom_range(0, AGE_TOP);
            default: refr = $urandom_range(0, 3000);
        endcase
        if ($urandom_range(0, 5) == 0)
            delay = $urandom_range(1, AGE_TOP);
        else
            delay = $urandom_range(1, 6000);
        write_config(rest, thr, rlv, gain, refr, delay);
    endtask

    // idle modes: none, sender gaps, receiver stalls, light both
    task automatic set_idle_mode(input int mode);
        case (mode % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 62; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 62; end
            default: begin send_idle_pct = 9;  stall_pct = 9;  end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers at their reset values: stimulus saturation both ways, firing,
    // rejected stimulus while refractory, countdown clamping at zero, leak that
    // clamps, and a packet whose age saturates and so reaches the 1 s delay.
    // Items one, two and four carry an extreme in the field they do not use.
    task automatic test_reset_defaults();
        set_idle_mode(0);
        send_item(CMD_TICK, LEVEL_MAX, '0);
        send_item(CMD_STIM, LEVEL_MAX, AGE_MAX);
        send_item(CMD_STIM, LEVEL_MAX, '0);
        send_item(CMD_TICK, LEVEL_MIN, 20'd1);
        send_item(CMD_STIM, LEVEL_MIN, '0);
        send_item(CMD_TICK, '0, AGE_MAX);
        send_item(CMD_STIM, LEVEL_MIN, '0);
        send_item(CMD_TICK, '0, AGE_MAX);
    endtask

    // Lowest threshold and no refractory time: every tick fires. Fill all slots,
    // drop one spike, then age all out at once on a tick that drops one more; with
    // a 1 us delay, a packet from a zero-length tick waits and arrives with the next.
    task automatic test_packet_store();
        wait_drained();
        write_config(0, int'(LEVEL_MIN), 0, 0, 0, AGE_TOP);
        repeat (MAX_PACKETS + 1)
            send_item(CMD_TICK, '0, '0);
        send_item(CMD_TICK, '0, AGE_MAX);
        wait_drained();
        write_reg(REG_AXON_DELAY, 1);
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_TICK, '0, 20'd1);
    endtask

    // Random phases, each with its own registers, idle modes taken in turn; one phase
    // at all register minima but an axon delay of 1, and one at all maxima.
    task automatic test_random_phases();
        for (int phase = 0; phase < 8; phase++)
        begin
            wait_drained();
            set_idle_mode(phase);
            if (phase == 2)
                write_config(int'(LEVEL_MIN), int'(LEVEL_MIN), int'(LEVEL_MIN), 0, 0, 1);
            else if (phase == 5)
                write_config(int'(LEVEL_MAX), int'(LEVEL_MAX), int'(LEVEL_MAX),
                             16777215, AGE_TOP, AGE_TOP);
            else
                load_random_config();
            repeat (PHASE_ITEMS)
                send_random_item();
        end
    endtask

    // Sender pauses mid-stream until the block has delivered everything.
    task automatic test_drain_pause();
        wait_drained();
        set_idle_mode(3);
        load_random_config();
        repeat (20)
            send_random_item();
        wait_drained();
        repeat (20)
            send_random_item();
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        item_valid   = 1'b0;
        command      = CMD_STIM;
        stimulus_mv  = '0;
        elapsed_us   = '0;
        result_stall = 1'b0;
        mismatches   = 0;
        cycle_count  = 0;
        send_idle_pct = 0;
        stall_pct    = 0;
        reset_neuron_mirror();

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_packet_store();
        test_random_phases();
        test_drain_pause();
        wait_drained();

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
